/* hdl/bb_pkg.sv */
// Shared types and constants of the 3x3 box blur.
`timescale 1ns / 1ps

package bb_pkg;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_W = 11;
  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd800;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd600;

  // Division by 9 as multiply by ceil(2^16 / 9), exact for sums up to 9 * 255
  localparam logic [12:0] DIV9_RECIP = 13'd7282;
  localparam logic [7:0]  ALPHA      = 8'hFF;

  typedef struct packed {
    logic       func;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } bb_in_t;

  typedef struct packed {
    logic [31:0] out_color;
    logic [9:0]  out_x;
    logic [9:0]  out_y;
    logic        frame_end;
  } bb_out_t;

  // Per-item control decided by the front end
  typedef struct packed {
    logic       emit;
    logic       frame_end;
    logic       col0_on;
    logic       col2_on;
    logic       row0_on;
    logic       row2_on;
    logic [9:0] out_x;
    logic [9:0] out_y;
  } bb_ctl_t;

endpackage

/* hdl/bb_front.sv */
// Front end: frame size registers, input position tracking and item classification.
`timescale 1ns / 1ps

module bb_front import bb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int AW         = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bb_in_t           in_data,
  input  logic             push_ready,
  output logic             push_valid,
  output logic [AW-1:0]    push_addr,
  output bb_ctl_t          push_ctl,
  output logic [23:0]      push_pix,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int EW0 = (WW > RW) ? WW : RW;
  localparam int EW  = (EW0 > CFG_W) ? EW0 : CFG_W;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [AW-1:0]    col;
  logic [RW-1:0]    row;

  logic [EW-1:0] w_raw, h_raw, w_e, h_e, c_e, r_e, ox_e, oy_e, c_inc;
  logic          row_start, normal, emit, fe, accept;

  always_comb begin
    w_raw = EW'(frame_width);
    h_raw = EW'(frame_height);
    if (w_raw == '0) begin
      w_e = EW'(1);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_e = EW'(MAX_WIDTH);
    end else begin
      w_e = w_raw;
    end
    if (h_raw == '0) begin
      h_e = EW'(1);
    end else if (h_raw > EW'(MAX_HEIGHT)) begin
      h_e = EW'(MAX_HEIGHT);
    end else begin
      h_e = h_raw;
    end
  end

  always_comb begin
    c_e       = EW'(col);
    r_e       = EW'(row);
    // Row start closes the last pixel of the row two back
    row_start = (c_e == '0) && (r_e >= EW'(2));
    normal    = (c_e != '0) && (r_e != '0);
    emit      = row_start || normal;
    ox_e      = row_start ? (w_e - EW'(1)) : (c_e - EW'(1));
    oy_e      = row_start ? (r_e - EW'(2)) : (r_e - EW'(1));
    fe        = emit && (ox_e == w_e - EW'(1)) && (oy_e == h_e - EW'(1));
    c_inc     = c_e + EW'(1);
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && push_ready;
  assign push_valid = in_valid;
  assign push_addr  = col;
  assign push_pix   = ((r_e < h_e) && !in_data.func) ?
                      {in_data.in_red, in_data.in_green, in_data.in_blue} : 24'd0;

  always_comb begin
    push_ctl.emit      = emit;
    push_ctl.frame_end = fe;
    push_ctl.col0_on   = (ox_e != '0);
    push_ctl.col2_on   = (ox_e != w_e - EW'(1));
    push_ctl.row0_on   = (oy_e != '0);
    push_ctl.row2_on   = (oy_e != h_e - EW'(1));
    push_ctl.out_x     = ox_e[9:0];
    push_ctl.out_y     = oy_e[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (fe) begin
        col <= '0;
        row <= '0;
      end else if (c_inc >= w_e) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= c_inc[AW-1:0];
      end
    end
  end

endmodule

/* hdl/bb_fifo.sv */
// Short queue between the front end and the blur back end.
`timescale 1ns / 1ps

module bb_fifo #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [NW-1:0]    count;
  logic             do_push, do_pop;

  assign ready      = (count != NW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rptr];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

/* hdl/bb_back.sv */
// Back end: line stores, window, masked 3x3 sums, divide by 9 and output register.
`timescale 1ns / 1ps

module bb_back import bb_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  logic [AW-1:0] head_addr,
  input  bb_ctl_t       head_ctl,
  input  logic [23:0]   head_pix,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output bb_out_t       out_data
);

  logic [23:0] upper_mem  [MAX_WIDTH];
  logic [23:0] middle_mem [MAX_WIDTH];

  logic          adv, fwd, s1_valid;
  logic [AW-1:0] s1_addr;
  bb_ctl_t       s1_ctl;
  logic [23:0]   s1_pix, rd_up, rd_mid;
  logic [23:0]   win1 [3];
  logic [23:0]   win2 [3];

  logic [23:0] tap [3][3];
  logic        col_on [3];
  logic        row_on [3];
  logic [11:0] sum [3];

  logic        s2_valid, s2_fe;
  logic [9:0]  s2_x, s2_y;
  logic [11:0] s2_sum [3];
  logic [24:0] prod [3];

  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid;
  // Same entry still being written by the item ahead
  assign fwd = s1_valid && (head_addr == s1_addr);

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      upper_mem[s1_addr] <= rd_mid;
    end
    if (adv) begin
      rd_up <= fwd ? rd_mid : upper_mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      middle_mem[s1_addr] <= s1_pix;
    end
    if (adv) begin
      rd_mid <= fwd ? s1_pix : middle_mem[head_addr];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tap[0][r] = win1[r];
      tap[1][r] = win2[r];
    end
    tap[2][0] = rd_up;
    tap[2][1] = rd_mid;
    tap[2][2] = s1_pix;
    col_on[0] = s1_ctl.col0_on;
    col_on[1] = 1'b1;
    col_on[2] = s1_ctl.col2_on;
    row_on[0] = s1_ctl.row0_on;
    row_on[1] = 1'b1;
    row_on[2] = s1_ctl.row2_on;
    for (int k = 0; k < 3; k++) begin
      sum[k] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (col_on[c] && row_on[r]) begin
            sum[k] = sum[k] + 12'(tap[c][r][8*k +: 8]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = 25'(s2_sum[k]) * 25'(DIV9_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr <= head_addr;
      s1_ctl  <= head_ctl;
      s1_pix  <= head_pix;
      if (s1_valid) begin
        win1 <= win2;
        win2 <= tap[2];
      end
      s2_sum <= sum;
      s2_x   <= s1_ctl.out_x;
      s2_y   <= s1_ctl.out_y;
      s2_fe  <= s1_ctl.frame_end;
      out_data.out_color <= {prod[2][23:16], prod[1][23:16], prod[0][23:16], ALPHA};
      out_data.out_x     <= s2_x;
      out_data.out_y     <= s2_y;
      out_data.frame_end <= s2_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= head_valid;
      s2_valid  <= s1_valid && s1_ctl.emit;
      out_valid <= s2_valid;
    end
  end

endmodule

/* hdl/box_blur_3x3_rgb.sv */
// Top level of the streaming 3x3 box blur over RGB frames.
// Throughput: one input word per cycle and at most one result word per cycle when out_ready stays high.
// Pipeline: the input word that causes a result passes the queue, s1, s2 and the output register;
//   in frame terms a pixel comes out one row plus one pixel after it went in.
// Reset (rst, synchronous, active high): positions clear, frame size returns to 800 x 600,
//   queue and pipeline empty. The line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module box_blur_3x3_rgb import bb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bb_in_t           in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bb_out_t          out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // Line store address width: one entry per column
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int QW     = AW + $bits(bb_ctl_t) + 24;
  localparam int QDEPTH = 4;

  // Front end to queue
  logic          push_valid, push_ready;
  logic [AW-1:0] push_addr;
  bb_ctl_t       push_ctl;
  logic [23:0]   push_pix;

  // Queue to back end
  logic          head_valid, pop;
  logic [QW-1:0] head_word;
  logic [AW-1:0] head_addr;
  bb_ctl_t       head_ctl;
  logic [23:0]   head_pix;

  // Classify each word: where it lands in the frame, which neighbors count,
  // and whether it finishes an output pixel
  bb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_addr  (push_addr),
    .push_ctl   (push_ctl),
    .push_pix   (push_pix),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Hold classified words while the back end is stalled by the consumer
  bb_fifo #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_valid),
    .push_data  ({push_addr, push_ctl, push_pix}),
    .ready      (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_word)
  );

  assign head_addr = head_word[QW-1 -: AW];
  assign head_ctl  = bb_ctl_t'(head_word[24 +: $bits(bb_ctl_t)]);
  assign head_pix  = head_word[23:0];

  // Line stores, window, sums and the divide by 9; advance only when the
  // output register can take a word
  bb_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_addr  (head_addr),
    .head_ctl   (head_ctl),
    .head_pix   (head_pix),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // After reset nothing is pending and the queue takes words
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // The pixel after the last one of a frame starts the next frame
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.frame_end |=>
      !out_valid || (out_data.out_x == 10'd0 && out_data.out_y == 10'd0))
    else $error("frame did not restart at origin");

  // Output columns advance by one or wrap to the start of a row
  a_column_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.frame_end |=>
      !out_valid || out_data.out_x == 10'd0 ||
      out_data.out_x == $past(out_data.out_x) + 10'd1)
    else $error("output column out of order");

endmodule

/* dv/box_blur_3x3_rgb_tb.sv */
// Self-checking testbench for the streaming 3x3 RGB box blur.
`timescale 1ns / 1ps

module box_blur_3x3_rgb_tb;
  import bb_pkg::*;

  // Item kinds carried in the func bit of an input word
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam int IDLE_PCT      = 37;    // chance in percent that a side idles in a cycle
  localparam int SETTLE_CYCLES = 12;    // margin beyond the block pipeline for silent words
  localparam int HOLD_CYCLES   = 250;   // long receiver hold-off that backs up the block
  localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all before giving up
  localparam int RANDOM_WORDS  = 450;
  localparam int LINE_DEPTH    = 1024;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  bb_in_t           in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  bb_out_t          out_data;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  // Stimulus and scoreboard storage
  bb_in_t  pixel_feed_q[$];   // words waiting to be offered to the block
  bb_out_t blurred_q[$];      // blurred pixels the block still owes us
  int      mismatches = 0;
  int      words_in = 0;      // input words accepted so far
  int      queued_words = 0;  // input words handed to the driver so far
  logic    steady_flow;
  logic    rx_hold_req = 1'b0;
  logic    rx_hold_done = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  // Shadow copy of the block state used for prediction
  int unsigned           img_w = 800;
  int unsigned           img_h = 600;
  int unsigned           col_pos = 0;
  int unsigned           row_pos = 0;
  logic [2:0][2:0][23:0] win = '0;  // win[column oldest first][row upper, middle, new]
  logic [23:0]           upper_store [0:LINE_DEPTH-1];
  logic [23:0]           middle_store [0:LINE_DEPTH-1];

  box_blur_3x3_rgb u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Drop all idling on both sides for a stretch in the middle of the run
  assign steady_flow = (words_in >= 700) && (words_in < 1100);

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Clamp a raw size register: zero acts as one, large values saturate
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > LINE_DEPTH) return LINE_DEPTH;
    return 32'(raw);
  endfunction

  // Average the 3x3 neighborhood per channel; taps outside the frame add zero,
  // yet the divisor stays 9
  function automatic logic [31:0] box_avg(input logic [2:0][2:0][23:0] nb,
                                          input int unsigned ox, input int unsigned oy);
    int unsigned sr, sg, sb;
    logic [7:0]  qr, qg, qb;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int c = 0; c < 3; c++) begin
      if (!((c == 0 && ox == 0) || (c == 2 && ox == img_w - 1))) begin
        for (int r = 0; r < 3; r++) begin
          if (!((r == 0 && oy == 0) || (r == 2 && oy == img_h - 1))) begin
            sr += 32'(nb[c][r][23:16]);
            sg += 32'(nb[c][r][15:8]);
            sb += 32'(nb[c][r][7:0]);
          end
        end
      end
    end
    qr = 8'(sr / 9);
    qg = 8'(sg / 9);
    qb = 8'(sb / 9);
    return {qr, qg, qb, ALPHA};
  endfunction

  // Advance the shadow state by one accepted word; return 1 when it releases a pixel
  function automatic bit blur_step(input bb_in_t word, output bb_out_t res);
    int unsigned           c, r, ox, oy;
    logic [23:0]           pix, up, mid;
    logic [2:0][2:0][23:0] nb;
    bit                    emit;
    c = col_pos;
    r = row_pos;
    if (c >= img_w) c = 0;
    pix = '0;
    emit = 1'b0;
    ox = 0;
    oy = 0;
    res = '0;
    // Drains inside the frame act as black; anything past the last row is a drain
    if (r < img_h && word.func == FUNC_PIXEL) pix = {word.in_red, word.in_green, word.in_blue};

    // Row start: finish the last pixel of the row two back before shifting
    if (c == 0 && r >= 2) begin
      nb = '0;
      nb[0] = win[1];
      nb[1] = win[2];
      ox = img_w - 1;
      oy = r - 2;
      res.out_color = box_avg(nb, ox, oy);
      emit = 1'b1;
    end

    up = upper_store[c[9:0]];
    mid = middle_store[c[9:0]];
    upper_store[c[9:0]] = mid;
    middle_store[c[9:0]] = pix;
    win[0] = win[1];
    win[1] = win[2];
    win[2][0] = up;
    win[2][1] = mid;
    win[2][2] = pix;

    if (c >= 1 && r >= 1) begin
      ox = c - 1;
      oy = r - 1;
      res.out_color = box_avg(win, ox, oy);
      emit = 1'b1;
    end

    c++;
    if (c >= img_w) begin
      c = 0;
      r++;
    end
    col_pos = c;
    row_pos = r;

    res.out_x = ox[9:0];
    res.out_y = oy[9:0];
    // Last pixel of the frame: flag it and rewind every position
    if (emit && ox == img_w - 1 && oy == img_h - 1) begin
      res.frame_end = 1'b1;
      col_pos = 0;
      row_pos = 0;
    end
    return emit;
  endfunction

  // Mirror a register write: either size restarts the frame and clears the window
  function automatic void apply_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    if (idx == REG_FRAME_WIDTH) img_w = clamp_dim(val);
    else img_h = clamp_dim(val);
    win = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver, monitor and watchdog
  // ---------------------------------------------------------------------------

  // Offer queued words; hold valid and payload until the block takes the word
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_feed_q.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data <= pixel_feed_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Toggle out_ready at random; on request, hold it low long enough to fill the block
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_req && !rx_hold_done) begin
      rx_hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check each result word against the oldest prediction, then predict for new input
  always @(posedge clk) begin : monitor
    bb_out_t got_word, want_word, new_word;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_word = out_data;
        if (blurred_q.size() == 0) begin
          $display("%0t unexpected result word: color %h x %0d y %0d end %b", $time,
                   got_word.out_color, got_word.out_x, got_word.out_y, got_word.frame_end);
          mismatches++;
        end else begin
          want_word = blurred_q.pop_front();
          if (got_word.out_color !== want_word.out_color) begin
            $display("%0t out_color mismatch: expected %h actual %h", $time,
                     want_word.out_color, got_word.out_color);
            mismatches++;
          end
          if (got_word.out_x !== want_word.out_x) begin
            $display("%0t out_x mismatch: expected %0d actual %0d", $time,
                     want_word.out_x, got_word.out_x);
            mismatches++;
          end
          if (got_word.out_y !== want_word.out_y) begin
            $display("%0t out_y mismatch: expected %0d actual %0d", $time,
                     want_word.out_y, got_word.out_y);
            mismatches++;
          end
          if (got_word.frame_end !== want_word.frame_end) begin
            $display("%0t frame_end mismatch: expected %b actual %b", $time,
                     want_word.frame_end, got_word.frame_end);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        words_in++;
        if (blur_step(in_data, new_word)) blurred_q.push_back(new_word);
      end
    end
  end

  // End the run when no handshake of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t timeout: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Append one word for the driver
  task automatic queue_word(input logic f, input logic [23:0] rgb);
    bb_in_t w;
    w.func = f;
    w.in_red = rgb[23:16];
    w.in_green = rgb[15:8];
    w.in_blue = rgb[7:0];
    pixel_feed_q.push_back(w);
    queued_words++;
  endtask

  // Random color, biased toward the channel extremes
  function automatic logic [23:0] rand_rgb();
    logic [23:0] v;
    v = 24'($urandom);
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(4))
        0: v[8*k +: 8] = 8'h00;
        1: v[8*k +: 8] = 8'hFF;
        default: ;
      endcase
    end
    return v;
  endfunction

  // Queue one frame at the current size plus the tail that flushes it; a ragged
  // frame is cut short at a random point and followed by noise
  task automatic queue_frame(input bit ragged);
    int   n_frame, n_total, cut;
    logic f;
    n_frame = int'(img_w * img_h);
    n_total = n_frame + int'(img_w) + 1;
    cut = ragged ? int'($urandom_range(n_total - 1)) : n_total;
    for (int i = 0; i < cut; i++) begin
      if (i < n_frame) f = ($urandom_range(9) == 0) ? FUNC_DRAIN : FUNC_PIXEL;
      else f = 1'($urandom_range(1));  // past the last row both kinds flush
      queue_word(f, rand_rgb());
    end
    if (ragged) begin
      repeat ($urandom_range(20)) begin
        f = 1'($urandom_range(1));
        queue_word(f, rand_rgb());
      end
    end
  endtask

  // Wait until every queued word is in and every predicted pixel is out
  task automatic wait_all_results();
    do @(negedge clk);
    while (pixel_feed_q.size() != 0 || in_valid || blurred_q.size() != 0);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Drain the block, let silent words clear the pipe, then write the chosen sizes
  task automatic reconfigure(input logic [1:0] which, input logic [CFG_W-1:0] raw_w,
                             input logic [CFG_W-1:0] raw_h);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (which[0]) write_reg(REG_FRAME_WIDTH, raw_w);
    if (which[1]) write_reg(REG_FRAME_HEIGHT, raw_h);
    @(negedge clk);
  endtask

  initial begin
    int               phase;
    int               n_frames;
    logic [1:0]       which;
    logic [CFG_W-1:0] raw_w, raw_h;

    upper_store = '{default: '0};
    middle_store = '{default: '0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // 3x2 frame: channel extremes, a drain inside the frame acting as black,
    // then a tail mixing pixels past the last row with drains
    reconfigure(2'b11, 11'd3, 11'd2);
    queue_word(FUNC_PIXEL, 24'hFFFFFF);
    queue_word(FUNC_PIXEL, 24'h000000);
    queue_word(FUNC_PIXEL, 24'hFF00FF);
    queue_word(FUNC_DRAIN, 24'hFFFFFF);
    queue_word(FUNC_PIXEL, 24'hFFFFFF);
    queue_word(FUNC_PIXEL, 24'h00FF00);
    queue_word(FUNC_PIXEL, 24'hFFFFFF);
    queue_word(FUNC_DRAIN, 24'h000000);
    queue_word(FUNC_PIXEL, 24'hFFFFFF);
    queue_word(FUNC_DRAIN, 24'hFFFFFF);

    // Zero sizes act as a single pixel frame
    reconfigure(2'b11, 11'd0, 11'd0);
    queue_word(FUNC_PIXEL, 24'hFFFFFF);
    queue_word(FUNC_DRAIN, 24'hFFFFFF);
    queue_word(FUNC_PIXEL, 24'hFFFFFF);

    // One column of white, three rows
    reconfigure(2'b11, 11'd1, 11'd3);
    repeat (3) queue_word(FUNC_PIXEL, 24'hFFFFFF);
    queue_word(FUNC_DRAIN, 24'h000000);
    queue_word(FUNC_PIXEL, 24'h123456);

    // One row of white, two columns
    reconfigure(2'b11, 11'd2, 11'd1);
    repeat (2) queue_word(FUNC_PIXEL, 24'hFFFFFF);
    repeat (3) queue_word(FUNC_DRAIN, 24'hFFFFFF);

    // Random part: small frames, mostly complete, some cut short with noise;
    // always run far enough to reach the receiver hold-off
    phase = 0;
    while (phase < 4 || queued_words < 25 + RANDOM_WORDS) begin
      case ($urandom_range(9))
        0: raw_w = 11'd0;
        1: raw_w = 11'd1;
        default: raw_w = CFG_W'($urandom_range(2, 16));
      endcase
      case ($urandom_range(9))
        0: raw_h = 11'd0;
        1: raw_h = 11'd1;
        default: raw_h = CFG_W'($urandom_range(2, 10));
      endcase
      case ($urandom_range(5))
        0: which = 2'b01;
        1: which = 2'b10;
        default: which = 2'b11;
      endcase
      if (phase == 3) begin
        // Big enough to keep the sender busy through the long receiver hold-off
        which = 2'b11;
        raw_w = 11'd8;
        raw_h = 11'd8;
      end
      reconfigure(which, raw_w, raw_h);
      if (phase == 3) rx_hold_req <= 1'b1;
      n_frames = (phase == 3) ? 2 : int'($urandom_range(1, 3));
      for (int f = 0; f < n_frames; f++) begin
        queue_frame($urandom_range(6) == 0);
        // Pause the sender mid-phase until the block has handed back everything
        if (phase == 1 && f == 0) wait_all_results();
      end
      phase++;
    end

    // Saturated height: one full-height column
    reconfigure(2'b11, 11'd1, 11'd2047);
    queue_frame(1'b0);

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
